// ===== hw/rtl/vrt_pkg.sv =====
package vrt_pkg;

    // default formats
    localparam int ORIGIN_FRAC_BITS = 12;
    localparam int DIR_ONE_BITS     = 12;
    localparam int T_FRAC_BITS      = 16;

    // fixed field widths
    localparam int ORG_W   = 32;
    localparam int DIR_W   = 14;
    localparam int REACH_W = 10;
    localparam int CELL_W  = 20;
    localparam int FACE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int RSQ_W   = 2 * REACH_W;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PROBE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;

    // crossing t special values
    localparam logic [31:0] T_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] T_SAT = 32'hFFFF_FFFE;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              div_init;
        logic              div_step;
        logic              setup;
        logic              pick;
        logic              sq;
        logic              mlo;
        logic              mhi;
        logic              step;
        logic              deact;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic opcode;
        logic solid;
        logic all_zero;
        logic active;
        logic div_all;
        logic beyond;
    } t_sts;

endpackage

// ===== hw/rtl/vrt_dp.sv =====
module vrt_dp #(
    parameter int OFB = vrt_pkg::ORIGIN_FRAC_BITS,
    parameter int DOB = vrt_pkg::DIR_ONE_BITS,
    parameter int TFB = vrt_pkg::T_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vrt_pkg::t_cmd                       i_cmd,
    output vrt_pkg::t_sts                       o_sts,
    input  logic                                i_opcode,
    input  logic signed [vrt_pkg::ORG_W-1:0]    i_origin_x,
    input  logic signed [vrt_pkg::ORG_W-1:0]    i_origin_y,
    input  logic signed [vrt_pkg::ORG_W-1:0]    i_origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_z,
    input  logic [vrt_pkg::REACH_W-1:0]         i_reach,
    input  logic                                i_solid,
    output logic [vrt_pkg::KIND_W-1:0]          o_kind,
    output logic signed [vrt_pkg::CELL_W-1:0]   o_voxel_x,
    output logic signed [vrt_pkg::CELL_W-1:0]   o_voxel_y,
    output logic signed [vrt_pkg::CELL_W-1:0]   o_voxel_z,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_x,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_y,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_z
);

    localparam int XW   = (DOB + 2 > vrt_pkg::DIR_W) ? DOB + 2 : vrt_pkg::DIR_W;
    localparam int MAGW = DOB + 1;
    localparam int QW   = TFB + DOB + 1;
    localparam int CNTW = $clog2(QW);
    localparam int SH   = TFB + DOB - OFB;
    localparam int MW   = (QW > 33) ? QW : 33;
    localparam int SQW  = 2 * DOB + 1;
    localparam int LW   = 2 * DOB + 2;
    localparam int PW   = 64 + LW;
    localparam int S    = 2 * TFB + 2 * DOB;
    localparam int CW   = (PW > vrt_pkg::RSQ_W + S) ? PW : vrt_pkg::RSQ_W + S;
    localparam logic signed [XW-1:0] D_ONE = XW'(64'd1 << DOB);
    localparam logic [31:0] FMASK = 32'((64'd1 << OFB) - 64'd1);
    localparam int CW_ = vrt_pkg::CELL_W;

    // captured item
    logic                       r_op, r_solid;
    logic [MAGW-1:0]            r_mag   [3];
    logic                       r_neg   [3];
    logic [31:0]                r_frac  [3];
    logic [CW_-1:0]             r_scell [3];
    logic [vrt_pkg::REACH_W-1:0] r_reach;

    // ray state
    logic [CW_-1:0]             r_cell  [3];
    logic [31:0]                r_next  [3];
    logic [31:0]                r_cstep [3];
    logic                       r_sneg  [3];
    logic [1:0]                 r_face  [3];
    logic [vrt_pkg::RSQ_W-1:0]  r_rsq;
    logic [LW-1:0]              r_lsq;
    logic                       r_active;

    // divider and reach check
    logic [DOB+1:0]             r_rem;
    logic [QW-1:0]              r_quo;
    logic [CNTW-1:0]            r_cnt;
    logic [2:0]                 r_didx;
    logic [1:0]                 r_ax;
    logic [31:0]                r_tsel;
    logic [63:0]                r_tsq;
    logic [PW-1:0]              r_prod;

    logic signed [vrt_pkg::ORG_W-1:0] org [3];
    logic signed [vrt_pkg::DIR_W-1:0] din [3];
    logic signed [XW-1:0]       dext [3], dcl [3];
    logic [MAGW-1:0]            mag_in [3];
    logic signed [31:0]         osh [3];

    // clamp the direction and split the origin
    always_comb begin
        org[0] = i_origin_x; org[1] = i_origin_y; org[2] = i_origin_z;
        din[0] = i_dir_x;    din[1] = i_dir_y;    din[2] = i_dir_z;
        for (int a = 0; a < 3; a++) begin
            dext[a] = XW'(din[a]);
            if (dext[a] > D_ONE)       dcl[a] = D_ONE;
            else if (dext[a] < -D_ONE) dcl[a] = -D_ONE;
            else                       dcl[a] = dext[a];
            mag_in[a] = (dcl[a] < 0) ? MAGW'(-dcl[a]) : MAGW'(dcl[a]);
            osh[a]    = org[a] >>> OFB;
        end
    end

    // dividend of the next division
    logic [2:0]      nidx;
    logic [1:0]      nax;
    logic [63:0]     nbase;
    logic [QW-1:0]   ndvd;
    always_comb begin
        nidx  = i_cmd.div_init ? 3'd0 : r_didx + 3'd1;
        nax   = nidx[2:1];
        nbase = r_neg[nax] ? 64'(r_frac[nax]) : (64'd1 << OFB) - 64'(r_frac[nax]);
        if (nidx[0]) ndvd = QW'(64'd1 << (TFB + DOB));
        else         ndvd = QW'(nbase << SH);
    end

    // one restoring divide step
    logic [MAGW-1:0] dmag;
    logic [DOB+1:0]  dtmp;
    logic            dge;
    logic [QW-1:0]   dq;
    logic            dlast;
    logic [31:0]     dval;
    always_comb begin
        dmag  = r_mag[r_didx[2:1]];
        dtmp  = {r_rem[DOB:0], r_quo[QW-1]};
        dge   = dtmp >= {1'b0, dmag};
        dq    = {r_quo[QW-2:0], dge};
        dlast = r_cnt == CNTW'(QW - 1);
        dval  = (MW'(dq) >= MW'(vrt_pkg::T_SAT)) ? vrt_pkg::T_SAT : 32'(dq);
    end

    // nearest boundary and reach test
    logic [1:0]      pax;
    logic [32:0]     tsum;
    logic [SQW-1:0]  msq [3];
    always_comb begin
        if (r_next[0] < r_next[1]) pax = (r_next[0] < r_next[2]) ? 2'd0 : 2'd2;
        else                       pax = (r_next[1] < r_next[2]) ? 2'd1 : 2'd2;
        tsum = 33'(r_next[r_ax]) + 33'(r_cstep[r_ax]);
        for (int a = 0; a < 3; a++) msq[a] = SQW'(r_mag[a]) * SQW'(r_mag[a]);
    end

    assign o_sts.opcode   = r_op;
    assign o_sts.solid    = r_solid;
    assign o_sts.all_zero = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
    assign o_sts.active   = r_active;
    assign o_sts.div_all  = dlast && (r_didx == 3'd5);
    assign o_sts.beyond   = (r_tsel >= vrt_pkg::T_SAT) ||
                            (CW'(r_prod) > (CW'(r_rsq) << S));

    // item capture, divider, multiplier
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_solid <= i_solid;
            r_reach <= i_reach;
            for (int a = 0; a < 3; a++) begin
                r_mag[a]   <= mag_in[a];
                r_neg[a]   <= dcl[a] < 0;
                r_frac[a]  <= 32'(org[a]) & FMASK;
                r_scell[a] <= osh[a][CW_-1:0];
            end
        end
        if (i_cmd.div_init || (i_cmd.div_step && dlast)) begin
            r_didx <= nidx;
            r_rem  <= '0;
            r_quo  <= ndvd;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= dge ? dtmp - {1'b0, dmag} : dtmp;
            r_quo <= dq;
            r_cnt <= r_cnt + CNTW'(1);
        end
        if (i_cmd.pick) begin
            r_ax   <= pax;
            r_tsel <= r_next[pax];
        end
        if (i_cmd.sq)  r_tsq  <= r_tsel * r_tsel;
        if (i_cmd.mlo) r_prod <= PW'(r_tsq[31:0]) * PW'(r_lsq);
        if (i_cmd.mhi) r_prod <= r_prod + ((PW'(r_tsq[63:32]) * PW'(r_lsq)) << 32);
    end

    // ray state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rsq    <= '0;
            r_lsq    <= '0;
            for (int a = 0; a < 3; a++) begin
                r_cell[a]  <= '0;
                r_next[a]  <= vrt_pkg::T_INF;
                r_cstep[a] <= '0;
                r_sneg[a]  <= 1'b0;
                r_face[a]  <= '0;
            end
        end else begin
            if (i_cmd.div_step && dlast) begin
                if (!r_didx[0]) r_next[r_didx[2:1]]  <= (dmag == '0) ? vrt_pkg::T_INF : dval;
                else            r_cstep[r_didx[2:1]] <= (dmag == '0) ? '0 : dval;
            end
            if (i_cmd.setup) begin
                r_active <= 1'b1;
                r_rsq    <= r_reach * r_reach;
                r_lsq    <= LW'(msq[0]) + LW'(msq[1]) + LW'(msq[2]);
                for (int a = 0; a < 3; a++) begin
                    r_cell[a] <= r_scell[a];
                    r_sneg[a] <= r_neg[a];
                    r_face[a] <= '0;
                end
            end
            if (i_cmd.step) begin
                r_cell[r_ax] <= r_sneg[r_ax] ? r_cell[r_ax] - CW_'(1) : r_cell[r_ax] + CW_'(1);
                r_next[r_ax] <= (tsum >= 33'(vrt_pkg::T_SAT)) ? vrt_pkg::T_SAT : tsum[31:0];
                // entry face opposes the step, other axes clear
                for (int a = 0; a < 3; a++) begin
                    if (2'(a) == r_ax) r_face[a] <= r_sneg[r_ax] ? 2'b01 : 2'b11;
                    else               r_face[a] <= '0;
                end
            end
            if (i_cmd.deact) r_active <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind <= i_cmd.kind;
            if (i_cmd.kind == vrt_pkg::KIND_MISS) begin
                o_voxel_x <= '0; o_voxel_y <= '0; o_voxel_z <= '0;
                o_face_x  <= '0; o_face_y  <= '0; o_face_z  <= '0;
            end else begin
                o_voxel_x <= r_cell[0]; o_voxel_y <= r_cell[1]; o_voxel_z <= r_cell[2];
                o_face_x  <= r_face[0]; o_face_y  <= r_face[1]; o_face_z  <= r_face[2];
            end
        end
    end

endmodule

// ===== hw/rtl/vrt_ctrl.sv =====
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  vrt_pkg::t_sts i_sts,
    output vrt_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_SETUP  = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_MLO    = 4'd5;
    localparam logic [3:0] S_MHI    = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]                 r_state, n_state;
    logic [vrt_pkg::KIND_W-1:0] r_kind, n_kind;
    logic                       r_oval, n_oval;
    logic                       out_free;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_oval;
    assign out_free    = !r_oval || !i_out_stall;

    // sequencing
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_oval  = r_oval && i_out_stall;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.opcode) begin
                    if (i_sts.all_zero) begin
                        o_cmd.deact = 1'b1;
                        n_kind  = vrt_pkg::KIND_MISS;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state = S_DIV;
                    end
                end else if (!i_sts.active) begin
                    n_kind  = vrt_pkg::KIND_MISS;
                    n_state = S_EMIT;
                end else if (i_sts.solid) begin
                    o_cmd.deact = 1'b1;
                    n_kind  = vrt_pkg::KIND_HIT;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_all) n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_kind  = vrt_pkg::KIND_PROBE;
                n_state = S_EMIT;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.beyond) begin
                    o_cmd.deact = 1'b1;
                    n_kind = vrt_pkg::KIND_MISS;
                end else begin
                    o_cmd.step = 1'b1;
                    n_kind = vrt_pkg::KIND_PROBE;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= vrt_pkg::KIND_MISS;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_oval  <= n_oval;
        end
    end

endmodule

// ===== hw/rtl/voxel_ray_traversal_core.sv =====
// start item: one shared radix-2 divider computes first-crossing and step t for each axis in turn;
//   an all-zero direction skips the divider and returns a miss
// answer item: a hit or no-ray miss goes straight to the result; a step or reach miss first runs
//   t squared, two 32-bit partial products of the reach test, and the compare
// one item at a time; a result waits in the output register while the next item is taken
// reset (synchronous, active low): no ray, all t infinite, output empty
module voxel_ray_traversal_core #(
    parameter int ORIGIN_FRAC_BITS = vrt_pkg::ORIGIN_FRAC_BITS,
    parameter int DIR_ONE_BITS     = vrt_pkg::DIR_ONE_BITS,
    parameter int T_FRAC_BITS      = vrt_pkg::T_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_x,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_y,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_z,
    input  logic [vrt_pkg::REACH_W-1:0]       i_reach,
    input  logic                              i_solid,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vrt_pkg::KIND_W-1:0]        o_kind,
    output logic signed [vrt_pkg::CELL_W-1:0] o_voxel_x,
    output logic signed [vrt_pkg::CELL_W-1:0] o_voxel_y,
    output logic signed [vrt_pkg::CELL_W-1:0] o_voxel_z,
    output logic signed [vrt_pkg::FACE_W-1:0] o_face_x,
    output logic signed [vrt_pkg::FACE_W-1:0] o_face_y,
    output logic signed [vrt_pkg::FACE_W-1:0] o_face_z
);

    vrt_pkg::t_cmd cmd;
    vrt_pkg::t_sts sts;

    // sequencer
    vrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and ray state
    vrt_dp #(
        .OFB (ORIGIN_FRAC_BITS),
        .DOB (DIR_ONE_BITS),
        .TFB (T_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_opcode   (i_opcode),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_reach    (i_reach),
        .i_solid    (i_solid),
        .o_kind     (o_kind),
        .o_voxel_x  (o_voxel_x),
        .o_voxel_y  (o_voxel_y),
        .o_voxel_z  (o_voxel_z),
        .o_face_x   (o_face_x),
        .o_face_y   (o_face_y),
        .o_face_z   (o_face_z)
    );

    // a loaded result is presented next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("result loaded but not presented");

    // a step only happens on a live ray
    a_step_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> sts.active)
        else $error("step without an active ray");

    // a miss carries no voxel or face; voxel x and all faces are checked
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == vrt_pkg::KIND_MISS) |->
        (o_voxel_x == '0 && o_face_x == '0 && o_face_y == '0 && o_face_z == '0))
        else $error("miss with nonzero payload");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // one expected result item
    typedef struct packed {
        logic [vrt_pkg::KIND_W-1:0] kind;
        logic [vrt_pkg::CELL_W-1:0] vx;
        logic [vrt_pkg::CELL_W-1:0] vy;
        logic [vrt_pkg::CELL_W-1:0] vz;
        logic [vrt_pkg::FACE_W-1:0] fx;
        logic [vrt_pkg::FACE_W-1:0] fy;
        logic [vrt_pkg::FACE_W-1:0] fz;
    } t_voxel_res;

    // walk predictor and queue of pending results
    class walk_scoreboard;
        logic [vrt_pkg::CELL_W-1:0] vcell [3];
        logic [31:0]       cross_t [3];
        logic [31:0]       delta_t [3];
        int                sgn [3];
        int                face [3];
        logic [19:0]       rsq;
        logic [63:0]       dlen_sq;
        bit                active;
        t_voxel_res        pending [$];
        int                errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                vcell[i] = '0;
                cross_t[i] = vrt_pkg::T_INF;
                delta_t[i] = '0;
                sgn[i] = 0;
                face[i] = 0;
            end
            rsq = '0;
            dlen_sq = '0;
            active = 0;
            errors = 0;
        endfunction

        function automatic logic [31:0] sat(logic [63:0] v);
            return (v >= 64'(vrt_pkg::T_SAT)) ? vrt_pkg::T_SAT : v[31:0];
        endfunction

        function automatic void push(logic [1:0] k, int ffx, int ffy, int ffz);
            t_voxel_res r;
            r.kind = k;
            if (k == vrt_pkg::KIND_MISS) begin
                r.vx = '0; r.vy = '0; r.vz = '0;
            end else begin
                r.vx = vcell[0]; r.vy = vcell[1]; r.vz = vcell[2];
            end
            r.fx = vrt_pkg::FACE_W'(ffx);
            r.fy = vrt_pkg::FACE_W'(ffy);
            r.fz = vrt_pkg::FACE_W'(ffz);
            pending.push_back(r);
        endfunction

        // note one accepted input transfer
        function automatic void note_input(logic op, logic signed [31:0] org [3],
                                           logic signed [13:0] dir [3],
                                           logic [9:0] reach, logic solid);
            longint d [3];
            longint o, fr, mag, dvd;
            logic [127:0] lhs, rhs;
            int ax;
            if (op == 1'b0) begin
                for (int i = 0; i < 3; i++) begin
                    d[i] = dir[i];
                    if (d[i] > 4096) d[i] = 4096;
                    if (d[i] < -4096) d[i] = -4096;
                end
                if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
                    active = 0;
                    push(vrt_pkg::KIND_MISS, 0, 0, 0);
                    return;
                end
                for (int i = 0; i < 3; i++) begin
                    o = org[i];
                    fr = o & 4095;
                    vcell[i] = vrt_pkg::CELL_W'((o - fr) >>> 12);
                    if (d[i] == 0) begin
                        cross_t[i] = vrt_pkg::T_INF; delta_t[i] = '0; sgn[i] = 0;
                    end else begin
                        mag = d[i] < 0 ? -d[i] : d[i];
                        dvd = d[i] > 0 ? 4096 - fr : fr;
                        cross_t[i] = sat(64'((dvd << 16) / mag));
                        delta_t[i] = sat(64'((64'd1 << 28) / mag));
                        sgn[i] = d[i] > 0 ? 1 : -1;
                    end
                    face[i] = 0;
                end
                rsq = 20'(reach) * 20'(reach);
                dlen_sq = 64'(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]);
                active = 1;
                push(vrt_pkg::KIND_PROBE, 0, 0, 0);
                return;
            end
            if (!active) begin
                push(vrt_pkg::KIND_MISS, 0, 0, 0);
                return;
            end
            if (solid) begin
                active = 0;
                push(vrt_pkg::KIND_HIT, face[0], face[1], face[2]);
                return;
            end
            if (cross_t[0] < cross_t[1]) ax = (cross_t[0] < cross_t[2]) ? 0 : 2;
            else ax = (cross_t[1] < cross_t[2]) ? 1 : 2;
            lhs = 128'(cross_t[ax]) * 128'(cross_t[ax]) * 128'(dlen_sq);
            rhs = 128'(rsq) << 56;
            if (cross_t[ax] >= vrt_pkg::T_SAT || lhs > rhs) begin
                active = 0;
                push(vrt_pkg::KIND_MISS, 0, 0, 0);
                return;
            end
            vcell[ax] = vcell[ax] + vrt_pkg::CELL_W'(sgn[ax]);
            cross_t[ax] = sat(64'(cross_t[ax]) + 64'(delta_t[ax]));
            for (int i = 0; i < 3; i++) face[i] = 0;
            face[ax] = -sgn[ax];
            push(vrt_pkg::KIND_PROBE, face[0], face[1], face[2]);
        endfunction

        // compare one accepted result transfer with the oldest expectation
        function automatic void check_result(t_voxel_res act);
            t_voxel_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result got %h", $time, act);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r.kind != act.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, act.kind);
                errors++;
            end
            if (exp_r.vx != act.vx || exp_r.vy != act.vy || exp_r.vz != act.vz) begin
                $display("%0t: voxel exp %h %h %h got %h %h %h", $time,
                         exp_r.vx, exp_r.vy, exp_r.vz, act.vx, act.vy, act.vz);
                errors++;
            end
            if (exp_r.fx != act.fx || exp_r.fy != act.fy || exp_r.fz != act.fz) begin
                $display("%0t: face exp %h %h %h got %h %h %h", $time,
                         exp_r.fx, exp_r.fy, exp_r.fz, act.fx, act.fy, act.fz);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic               i_opcode = 0;
    logic signed [31:0] i_origin_x = 0, i_origin_y = 0, i_origin_z = 0;
    logic signed [13:0] i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    logic [9:0]         i_reach = 0;
    logic               i_solid = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [1:0]         o_kind;
    logic signed [19:0] o_voxel_x, o_voxel_y, o_voxel_z;
    logic signed [1:0]  o_face_x, o_face_y, o_face_z;

    walk_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    always #4 i_clk = ~i_clk;

    voxel_ray_traversal_core dut (.*);

    // accept monitor: inputs and results
    always @(posedge i_clk) begin
        logic signed [31:0] org [3];
        logic signed [13:0] dir [3];
        t_voxel_res r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            org[0] = i_origin_x; org[1] = i_origin_y; org[2] = i_origin_z;
            dir[0] = i_dir_x; dir[1] = i_dir_y; dir[2] = i_dir_z;
            sb.note_input(i_opcode, org, dir, i_reach, i_solid);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.kind = o_kind;
            r.vx = o_voxel_x; r.vy = o_voxel_y; r.vz = o_voxel_z;
            r.fx = o_face_x; r.fy = o_face_y; r.fz = o_face_z;
            sb.check_result(r);
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // drive one item and wait for its transfer; valid stays up for the next item
    task automatic send_item(logic op, logic signed [31:0] ox, logic signed [31:0] oy,
                             logic signed [31:0] oz, logic signed [13:0] dx,
                             logic signed [13:0] dy, logic signed [13:0] dz,
                             logic [9:0] rch, logic sld);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_opcode <= op;
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        i_reach <= rch;
        i_solid <= sld;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic signed [13:0] rand_dir();
        case ($urandom_range(9))
            0: return 14'($urandom());
            1: return 0;
            2: return 4096;
            3: return -4096;
            default: return 14'sd0 + 14'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_org();
        if ($urandom_range(4) == 0) return $urandom();
        return $signed($urandom_range(65535)) - 32768;
    endfunction

    // one random ray: a start, then mostly empty answers; now and then a lone answer instead
    task automatic random_ray(output int n);
        int steps;
        n = 0;
        if ($urandom_range(9) == 0) begin
            send_item(1'b1, $urandom(), $urandom(), $urandom(), rand_dir(), rand_dir(),
                      rand_dir(), 10'($urandom()), 1'($urandom()));
            n++;
            return;
        end
        send_item(1'b0, rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(),
                  rand_dir(),
                  10'(($urandom_range(7) == 0) ? $urandom() : $urandom_range(6)),
                  1'($urandom()));
        n++;
        steps = $urandom_range(12);
        for (int s = 0; s < steps; s++) begin
            send_item(1'b1, $urandom(), $urandom(), $urandom(), rand_dir(), rand_dir(),
                      rand_dir(), 10'($urandom()), ($urandom_range(9) == 0));
            n++;
        end
    endtask

    initial begin
        int n, total;
        sb = new();
        send_idle_pct = 19;
        recv_idle_pct = 49;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: answer with no ray, zero direction, extremes
        send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(1'b0, 0, 0, 0, 0, 0, 0, 5, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000, 4096, -4096, 0,
                  10'h3FF, 1'b0);
        repeat (4) send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(1'b0, 32'h0000_0800, -32'sd2048, 32'h0000_0000, 14'h1FFF, 14'h2000,
                  1, 3, 1'b1);
        repeat (6) send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(1'b0, 32'h0000_0FFF, 32'h0000_0001, 32'hFFFF_F000, 3, -5, 4000, 0, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, -1, 2, 1'b0);
        repeat (4) send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 1'b0);

        total = 0;
        while (total < 650) begin
            if (total > 433) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end else if (total > 216) begin
                send_idle_pct = 49; recv_idle_pct = 19;
            end
            random_ray(n);
            total += n;
        end
        i_in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("voxel_ray_traversal_core test passed");
        else
            $display("voxel_ray_traversal_core test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("voxel_ray_traversal_core test failed");
        $finish;
    end
endmodule
